@@ rtl/ole_pkg.sv @@
// Shared types and codes of the ordered list engine.
package ole_pkg;

   localparam int DATA_W       = 32;
   localparam int FIELD_W      = 7;
   localparam int OP_W         = 3;
   localparam int TDATA_W      = 40;
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [OP_W-1:0] {
      OP_HEAD   = 3'd0,
      OP_TAIL   = 3'd1,
      OP_POS    = 3'd2,
      OP_READ   = 3'd3,
      OP_REMOVE = 3'd4,
      OP_SUM    = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_BADPOS   = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_FULL     = 3'd3,
      STS_EMPTY    = 3'd4
   } status_type;

   // per-cycle command to every cell
   typedef struct packed {
      logic ins;   // open a gap at the insert position and load the new item
      logic rm;    // close the gap left by the first match
   } cell_ctl_type;

   // scan lanes handed from one cell to the next
   typedef struct packed {
      logic [DATA_W-1:0] acc;    // running wrapped sum
      logic [DATA_W-1:0] data;   // entry picked at the read position
      logic              found;  // a match lies at or before this cell
   } wave_type;

endpackage

@@ rtl/ole_cell.sv @@
// One list cell: holds one entry and one stage of the scan lanes.
module ole_cell #(
   parameter int IDX = 0,
   parameter int IW  = 7
) (
   input  logic                      clock,
   input  ole_pkg::cell_ctl_type     ctl,
   input  logic [IW-1:0]             ins_pos,
   input  logic [IW-1:0]             rd_pos,
   input  logic [IW-1:0]             count,
   input  logic [ole_pkg::DATA_W-1:0] ins_value,
   input  logic [ole_pkg::DATA_W-1:0] key_value,
   input  logic [ole_pkg::DATA_W-1:0] left_entry,
   input  logic [ole_pkg::DATA_W-1:0] right_entry,
   input  ole_pkg::wave_type         wave_in,
   output logic [ole_pkg::DATA_W-1:0] entry_out,
   output ole_pkg::wave_type         wave_out
);
   import ole_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [DATA_W-1:0] entry_ff, entry_in;
   wave_type          wave_ff, wave_in_nx;
   logic              active;
   logic              hit;

   assign active = (MY_IDX < count);
   assign hit    = active && (entry_ff == key_value);

   // shift up, load, shift down or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && (MY_IDX > ins_pos)) begin
         entry_in = left_entry;
      end else if (ctl.ins && (MY_IDX == ins_pos)) begin
         entry_in = ins_value;
      end else if (ctl.rm && wave_ff.found) begin
         entry_in = right_entry;
      end
   end

   always_comb begin
      wave_in_nx.acc   = wave_in.acc + (active ? entry_ff : '0);
      wave_in_nx.data  = (MY_IDX == rd_pos) ? entry_ff : wave_in.data;
      wave_in_nx.found = wave_in.found | hit;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      wave_ff  <= wave_in_nx;
   end

   assign entry_out = entry_ff;
   assign wave_out  = wave_ff;

endmodule

@@ rtl/ordered_list_engine.sv @@
// Top level of the ordered list engine: request decode, cell chain and result register.
//
// A bounded ordered list of up to CAPACITY signed 32-bit entries, one entry per
// cell in a chain. Each request item gives exactly one response item. Inserts
// (head, tail, position), clear, unused codes and every request refused at once
// (full, empty, invalid position) load the response as the request is taken; an
// insert shifts all later entries up by one cell on that same clock edge. Read,
// remove and sum scan the chain: a wave of sum, pick and match lanes walks the
// chain one cell per cycle, and the response item is loaded when the wave reaches
// the last cell. For remove, the cells from the first match on pull their right
// neighbour as the scan ends. No new request is taken until the scan has ended,
// so a scan request is through before the next one is taken. A new request is
// taken once the output register is empty, or in the cycle in which the previous
// response item leaves it, as long as the engine is not scanning. There is no
// clearing pass: entries beyond the count are never observed.
module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: tuser = operation[2:0]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ole_pkg::OP_W-1:0]    req_tuser,
   // request: tdata = value[31:0], position[38:32], zero[39]
   input  logic [ole_pkg::TDATA_W-1:0] req_tdata,
   // response: tuser = status[2:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2:0]                  rsp_tuser,
   // response: tdata = data[31:0], count[38:32], zero[39]
   output logic [ole_pkg::TDATA_W-1:0] rsp_tdata
);
   import ole_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);     // count and scan step width
   localparam int IW = (CW > FIELD_W) ? CW : FIELD_W;  // position compare width
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } fsm_type;

   fsm_type            state_ff, state_in;
   op_type             op_ff, op_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [FIELD_W-1:0] rsp_count_ff, rsp_count_in;

   op_type             req_op;
   logic [DATA_W-1:0]  req_value;
   logic [IW-1:0]      req_pos;
   logic               req_fire;
   logic               rsp_load;
   logic [IW-1:0]      ins_pos;
   logic [IW-1:0]      count_w;
   cell_ctl_type       ctl;
   logic               scan_done;

   logic [DATA_W-1:0]  entry_w [CAPACITY];
   wave_type           wave_w  [CAPACITY];

   // unpack the request item
   assign req_op    = op_type'(req_tuser);
   assign req_value = req_tdata[DATA_W-1:0];
   assign req_pos   = IW'(req_tdata[DATA_W +: FIELD_W]);

   // take a request when idle and the result register is free or emptying
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign count_w    = IW'(count_ff);
   assign scan_done  = (state_ff == S_SCAN) && (step_ff == CAP_C);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STS_OK;
      rsp_data_in   = '0;
      ctl           = '0;
      ins_pos       = req_pos;

      if (req_fire) begin
         op_in    = req_op;
         value_in = req_value;
         pos_in   = req_pos;
         step_in  = '0;
         rsp_load = 1'b1;
         case (req_op)
            OP_HEAD, OP_TAIL, OP_POS: begin
               if (req_op == OP_HEAD) begin
                  ins_pos = '0;
               end else if (req_op == OP_TAIL) begin
                  ins_pos = count_w;
               end
               if (count_ff == CAP_C) begin
                  rsp_status_in = STS_FULL;
               end else if ((req_op == OP_POS) && (req_pos > count_w)) begin
                  rsp_status_in = STS_BADPOS;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_READ: begin
               if (count_ff == '0) begin
                  rsp_status_in = STS_EMPTY;
               end else if (req_pos >= count_w) begin
                  rsp_status_in = STS_BADPOS;
               end else begin
                  rsp_load = 1'b0;
                  state_in = S_SCAN;
               end
            end
            OP_REMOVE, OP_SUM: begin
               if (count_ff == '0) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rsp_load = 1'b0;
                  state_in = S_SCAN;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_SCAN) begin
         step_in = step_ff + 1'b1;
         if (scan_done) begin
            // the wave has reached the last cell: read the lanes out
            state_in = S_IDLE;
            rsp_load = 1'b1;
            case (op_ff)
               OP_READ: begin
                  rsp_data_in = wave_w[CAPACITY-1].data;
               end
               OP_SUM: begin
                  rsp_data_in = wave_w[CAPACITY-1].acc;
               end
               OP_REMOVE: begin
                  if (wave_w[CAPACITY-1].found) begin
                     ctl.rm   = 1'b1;
                     count_in = count_ff - 1'b1;
                  end else begin
                     rsp_status_in = STS_NOTFOUND;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rsp_count_in = FIELD_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // the chain: cell 0 holds the head of the list
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_entry;
      logic [DATA_W-1:0] right_entry;
      wave_type          wave_in;

      if (i == 0) begin : g_first
         assign left_entry = req_value;
         assign wave_in    = '0;
      end else begin : g_mid
         assign left_entry = entry_w[i-1];
         assign wave_in    = wave_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end

      ole_cell #(
         .IDX (i),
         .IW  (IW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .ins_pos     (ins_pos),
         .rd_pos      (pos_ff),
         .count       (count_w),
         .ins_value   (req_value),
         .key_value   (value_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .wave_in     (wave_in),
         .entry_out   (entry_w[i]),
         .wave_out    (wave_w[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_data_ff};

   // the result register is empty for the whole of a scan
   a_scan_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !rsp_valid_ff)
      else $error("result held during a scan");

   // the list never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count beyond capacity");

   // an accepted insert grows the list by exactly one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance the count");

   // the end of a scan returns to idle with a result ready
   a_scan_finish: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("scan ended without a result");

endmodule
